@@ rtl/agtr_pkg.sv @@
package agtr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int ACC_W      = 40;
	localparam int RES_W      = 42;
	localparam int ABS_W      = 41;
	localparam int PROD_W     = 56;
	localparam int MUL_SPLIT  = 20;
	localparam int HOP_W      = 11;
	localparam int HOP_CNT_W  = 10;
	localparam int RATIO_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MAG_W      = 32;
	localparam int ROOT_W     = 64;

	localparam logic [HOP_W-1:0] HOP_MAX   = 11'd1024;
	localparam logic [HOP_W-1:0] HOP_RESET = 11'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_COS   = 3'd0,
		REG_MARK_SIN   = 3'd1,
		REG_SPACE_COS  = 3'd2,
		REG_SPACE_SIN  = 3'd3,
		REG_HOP_LENGTH = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] mark_cos;
		logic signed [COEF_W-1:0] mark_sin;
		logic signed [COEF_W-1:0] space_cos;
		logic signed [COEF_W-1:0] space_sin;
	} coef_t;

	typedef struct packed {
		logic signed [RES_W-1:0] mark_re;
		logic signed [RES_W-1:0] mark_im;
		logic signed [RES_W-1:0] space_re;
		logic signed [RES_W-1:0] space_im;
	} tone_res_t;

endpackage

@@ rtl/agtr_sample_if.sv @@
interface agtr_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [agtr_pkg::SAMPLE_W-1:0] audio_sample;

	modport source (output valid, output audio_sample, input ready);
	modport sink (input valid, input audio_sample, output ready);
endinterface

@@ rtl/agtr_ratio_if.sv @@
interface agtr_ratio_if;
	logic                         valid;
	logic                         ready;
	logic [agtr_pkg::RATIO_W-1:0] mark_ratio;

	modport source (output valid, output mark_ratio, input ready);
	modport sink (input valid, input mark_ratio, output ready);
endinterface

@@ rtl/agtr_cfg_if.sv @@
interface agtr_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [agtr_pkg::CFG_IDX_W-1:0]  index;
	logic [agtr_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/agtr_front.sv @@
module agtr_front #(
	parameter int WINDOW = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [agtr_pkg::SAMPLE_W-1:0] in_sample,
	input  logic [agtr_pkg::HOP_W-1:0]           hop_length,
	output logic                                 cmd_valid,
	input  logic                                 cmd_ready,
	output logic signed [agtr_pkg::SAMPLE_W-1:0] cmd_sample,
	output logic [$clog2(WINDOW)-1:0]            cmd_addr,
	output logic [$clog2(WINDOW)-1:0]            cmd_start,
	output logic                                 cmd_trig
);
	localparam int AW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	logic [FW-1:0]                  fill_q;
	logic [AW-1:0]                  head_q;
	logic [agtr_pkg::HOP_CNT_W-1:0] hop_q;
	logic                           full;
	logic [agtr_pkg::HOP_W-1:0]     hop_eff;
	logic [agtr_pkg::HOP_W-1:0]     hop_next;
	logic [AW-1:0]                  head_inc;
	logic                           accept;

	always_comb begin
		if (hop_length == '0) begin
			hop_eff = agtr_pkg::HOP_W'(1);
		end else if (hop_length > agtr_pkg::HOP_MAX) begin
			hop_eff = agtr_pkg::HOP_MAX;
		end else begin
			hop_eff = hop_length;
		end
	end

	assign full       = (fill_q == FW'(WINDOW));
	assign hop_next   = {1'b0, hop_q} + agtr_pkg::HOP_W'(1);
	assign head_inc   = (head_q == AW'(WINDOW - 1)) ? '0 : head_q + AW'(1);
	assign in_ready   = cmd_ready;
	assign cmd_valid  = in_valid;
	assign cmd_sample = in_sample;
	assign cmd_addr   = full ? head_q : fill_q[AW-1:0];
	assign cmd_start  = head_inc;
	assign cmd_trig   = full && (hop_next >= hop_eff);
	assign accept     = in_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			head_q <= '0;
			hop_q  <= '0;
		end else if (accept) begin
			if (!full) begin
				fill_q <= fill_q + FW'(1);
			end else begin
				head_q <= head_inc;
				if (cmd_trig) begin
					hop_q <= '0;
				end else begin
					hop_q <= hop_next[agtr_pkg::HOP_CNT_W-1:0];
				end
			end
		end
	end
endmodule

@@ rtl/agtr_queue.sv @@
module agtr_queue #(
	parameter int DW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_data
);
	logic [DW-1:0] buf_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

@@ rtl/agtr_back.sv @@
module agtr_back #(
	parameter int WINDOW = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  logic signed [agtr_pkg::SAMPLE_W-1:0] cmd_sample,
	input  logic [$clog2(WINDOW)-1:0]            cmd_addr,
	input  logic [$clog2(WINDOW)-1:0]            cmd_start,
	input  logic                                 cmd_trig,
	input  agtr_pkg::coef_t                      coef,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output agtr_pkg::tone_res_t                  res
);
	localparam int AW = $clog2(WINDOW);
	localparam int SPLIT = agtr_pkg::MUL_SPLIT;
	localparam int ACC = agtr_pkg::ACC_W;
	localparam int PW = agtr_pkg::PROD_W;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] S0_MAX = 58'sd549755813887;
	localparam logic signed [SW-1:0] S0_MIN = -58'sd549755813888;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_MLO  = 7'b0000100,
		S_MHI  = 7'b0001000,
		S_SUM  = 7'b0010000,
		S_UPD  = 7'b0100000,
		S_HAND = 7'b1000000
	} back_state_t;

	back_state_t                          state_q;
	logic signed [agtr_pkg::SAMPLE_W-1:0] win_mem [WINDOW];
	logic signed [agtr_pkg::SAMPLE_W-1:0] rd_q;
	logic [AW-1:0]                        ptr_q;
	logic [AW-1:0]                        idx_q;
	logic                                 tone_q;
	logic                                 fin_q;
	logic [1:0]                           j_q;
	logic signed [ACC-1:0]                p1_q [2];
	logic signed [ACC-1:0]                p2_q [2];
	logic signed [agtr_pkg::RES_W-1:0]    res_q [4];
	logic signed [36:0]                   plo_q;
	logic signed [35:0]                   phi_q;
	logic signed [PW-1:0]                 prod_q;

	logic                                 cur_tone;
	logic                                 use_sin;
	logic signed [agtr_pkg::COEF_W-1:0]   coef_sel;
	logic signed [ACC-1:0]                v;
	logic signed [PW-1:0]                 t14;
	logic signed [PW-1:0]                 t15;
	logic signed [SW-1:0]                 s0;
	logic signed [ACC-1:0]                s0_sat;
	logic signed [PW-1:0]                 fin_val;

	assign cur_tone  = fin_q ? j_q[1] : tone_q;
	assign use_sin   = fin_q && j_q[0];
	assign v         = p1_q[cur_tone];
	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_HAND);
	assign res       = '{res_q[0], res_q[1], res_q[2], res_q[3]};

	always_comb begin
		case ({cur_tone, use_sin})
			2'b00:   coef_sel = coef.mark_cos;
			2'b01:   coef_sel = coef.mark_sin;
			2'b10:   coef_sel = coef.space_cos;
			default: coef_sel = coef.space_sin;
		endcase
	end

	// Rounded shifts of the product: half up, then an arithmetic shift.
	always_comb begin
		t14 = (prod_q + PW'(64'sd8192)) >>> 14;
		t15 = (prod_q + PW'(64'sd16384)) >>> 15;
		s0  = SW'(t14) + SW'(rd_q) - SW'(p2_q[cur_tone]);
		if (s0 > S0_MAX) begin
			s0_sat = ACC'(S0_MAX);
		end else if (s0 < S0_MIN) begin
			s0_sat = ACC'(S0_MIN);
		end else begin
			s0_sat = s0[ACC-1:0];
		end
		fin_val = use_sin ? t15 : t15 - PW'(p2_q[cur_tone]);
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			win_mem[cmd_addr] <= cmd_sample;
		end
		if (state_q == S_READ) begin
			rd_q <= win_mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_MLO:   plo_q <= coef_sel * $signed({1'b0, v[SPLIT-1:0]});
			S_MHI:   phi_q <= coef_sel * $signed(v[ACC-1:SPLIT]);
			S_SUM:   prod_q <= $signed({phi_q, {SPLIT{1'b0}}})
				+ $signed({{(PW - 37){plo_q[36]}}, plo_q});
			S_UPD: begin
				if (fin_q) begin
					res_q[j_q] <= fin_val[agtr_pkg::RES_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			idx_q   <= '0;
			tone_q  <= 1'b0;
			fin_q   <= 1'b0;
			j_q     <= '0;
			p1_q[0] <= '0;
			p1_q[1] <= '0;
			p2_q[0] <= '0;
			p2_q[1] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_trig) begin
						ptr_q   <= cmd_start;
						idx_q   <= '0;
						tone_q  <= 1'b0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_MLO;
				S_MLO:  state_q <= S_MHI;
				S_MHI:  state_q <= S_SUM;
				S_SUM:  state_q <= S_UPD;
				S_UPD: begin
					if (fin_q) begin
						if (j_q == 2'd3) begin
							state_q <= S_HAND;
						end else begin
							j_q     <= j_q + 2'd1;
							state_q <= S_MLO;
						end
					end else begin
						p2_q[tone_q] <= p1_q[tone_q];
						p1_q[tone_q] <= s0_sat;
						if (!tone_q) begin
							tone_q  <= 1'b1;
							state_q <= S_MLO;
						end else begin
							tone_q <= 1'b0;
							if (idx_q == AW'(WINDOW - 1)) begin
								fin_q   <= 1'b1;
								j_q     <= '0;
								state_q <= S_MLO;
							end else begin
								idx_q   <= idx_q + AW'(1);
								ptr_q   <= (ptr_q == AW'(WINDOW - 1)) ? '0 : ptr_q + AW'(1);
								state_q <= S_READ;
							end
						end
					end
				end
				S_HAND: begin
					if (res_ready) begin
						p1_q[0] <= '0;
						p1_q[1] <= '0;
						p2_q[0] <= '0;
						p2_q[1] <= '0;
						fin_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/agtr_ratio.sv @@
module agtr_ratio (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         res_valid,
	output logic                         res_ready,
	input  agtr_pkg::tone_res_t          res,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [agtr_pkg::RATIO_W-1:0] out_ratio
);
	localparam int AB = agtr_pkg::ABS_W;
	localparam int RW = agtr_pkg::ROOT_W;
	localparam int MW = agtr_pkg::MAG_W;

	typedef enum logic [7:0] {
		R_IDLE = 8'b00000001,
		R_NORM = 8'b00000010,
		R_SQA  = 8'b00000100,
		R_SQB  = 8'b00001000,
		R_ROOT = 8'b00010000,
		R_DSET = 8'b00100000,
		R_DIV  = 8'b01000000,
		R_OUT  = 8'b10000000
	} ratio_state_t;

	ratio_state_t                 state_q;
	logic [AB-1:0]                a_q [4];
	logic                         tone_q;
	logic [RW-1:0]                n_q;
	logic [RW-1:0]                root_q;
	logic [RW-1:0]                bit_q;
	logic [MW-1:0]                mm_q;
	logic [MW:0]                  sum_q;
	logic [MW:0]                  rem_q;
	logic [16:0]                  quo_q;
	logic [3:0]                   step_q;
	logic                         out_valid_q;
	logic [agtr_pkg::RATIO_W-1:0] out_q;

	logic                         big;
	logic [30:0]                  op;
	logic [61:0]                  sq;
	logic [RW-1:0]                cand;
	logic                         take;
	logic [RW-1:0]                root_nxt;
	logic [MW+1:0]                r2;
	logic                         q16;

	function automatic logic [AB-1:0] abs_of(input logic signed [agtr_pkg::RES_W-1:0] x);
		logic signed [agtr_pkg::RES_W-1:0] m;
		m = x[agtr_pkg::RES_W-1] ? -x : x;
		return m[AB-1:0];
	endfunction

	assign res_ready = (state_q == R_IDLE);
	assign out_valid = out_valid_q;
	assign out_ratio = out_q;

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 4; i++) begin
			big = big | (|a_q[i][AB-1:31]);
		end
		op       = (state_q == R_SQA) ? a_q[{tone_q, 1'b0}][30:0] : a_q[{tone_q, 1'b1}][30:0];
		sq       = op * op;
		cand     = root_q + bit_q;
		take     = (n_q >= cand);
		root_nxt = take ? (root_q >> 1) + bit_q : root_q >> 1;
		r2       = {rem_q, 1'b0};
		q16      = ({1'b0, mm_q} >= sum_q);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				a_q[0] <= abs_of(res.mark_re);
				a_q[1] <= abs_of(res.mark_im);
				a_q[2] <= abs_of(res.space_re);
				a_q[3] <= abs_of(res.space_im);
			end
			R_NORM: begin
				if (big) begin
					for (int i = 0; i < 4; i++) begin
						a_q[i] <= a_q[i] >> 1;
					end
				end
			end
			R_SQA: n_q <= RW'(sq);
			R_SQB: begin
				n_q    <= n_q + RW'(sq);
				root_q <= '0;
				bit_q  <= RW'(1) << 62;
			end
			R_ROOT: begin
				if (take) begin
					n_q <= n_q - cand;
				end
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				if (bit_q[0]) begin
					if (!tone_q) begin
						mm_q <= root_nxt[MW-1:0];
					end else begin
						sum_q <= {1'b0, mm_q} + {1'b0, root_nxt[MW-1:0]};
					end
				end
			end
			R_DSET: begin
				// Integer part of mark/sum is at most one.
				rem_q  <= {1'b0, mm_q} - (q16 ? sum_q : '0);
				quo_q  <= (sum_q == '0) ? '0 : {16'd0, q16};
				step_q <= '0;
			end
			R_DIV: begin
				if (r2 >= {1'b0, sum_q}) begin
					rem_q <= (MW+1)'(r2 - {1'b0, sum_q});
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= r2[MW:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
				step_q <= step_q + 4'd1;
			end
			R_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q <= quo_q[16] ? '1 : quo_q[15:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= R_IDLE;
			tone_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == R_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				R_IDLE: begin
					if (res_valid) begin
						state_q <= R_NORM;
					end
				end
				R_NORM: begin
					if (!big) begin
						tone_q  <= 1'b0;
						state_q <= R_SQA;
					end
				end
				R_SQA: state_q <= R_SQB;
				R_SQB: state_q <= R_ROOT;
				R_ROOT: begin
					if (bit_q[0]) begin
						if (!tone_q) begin
							tone_q  <= 1'b1;
							state_q <= R_SQA;
						end else begin
							state_q <= R_DSET;
						end
					end
				end
				R_DSET: state_q <= (sum_q == '0) ? R_OUT : R_DIV;
				R_DIV: begin
					if (step_q == 4'd15) begin
						state_q <= R_OUT;
					end
				end
				R_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/afsk_goertzel_tone_ratio_top.sv @@
// Two-tone Goertzel AFSK detector over a sliding window of WINDOW samples.
// Audio samples arrive on the samples channel, one per valid/ready transfer.
// Results leave on the ratios channel as mark/(mark+space) in unsigned Q0.16.
// The cfg channel writes the mark and space cosine/sine registers and
// hop_length by register index; it is always ready and takes effect at once.
// Configuration is meant to be written only while the block is idle.
// Until WINDOW samples have been stored, samples are only kept. After that
// every hop_length-th sample starts a walk of the whole window, oldest first.
// A sample that does not start a walk is only written into the window. A
// sample that does is written and then starts a walk of the whole window (a
// 16x21 and a 16x20 partial product per tone and entry, and one window-memory
// read per entry), then passes the ratio unit for the shifts, two 32-step
// square roots and a 17-step division.
// A two-entry queue sits between the sample front end and the walk, so the
// front keeps taking samples while the walk runs until the queue fills.
// The ratio unit holds its answer in an output register; when the receiver
// stalls, the walk for the next hop still proceeds and waits at its hand-off.
// Reset clears all control state and the recurrences, empties the window
// and sets hop_length to 32 and the tone registers to zero.
module afsk_goertzel_tone_ratio_top #(
	parameter int WINDOW = 64
) (
	input logic           clk,
	input logic           arst_n,
	agtr_sample_if.sink   samples,
	agtr_ratio_if.source  ratios,
	agtr_cfg_if.sink      cfg
);
	localparam int AW = $clog2(WINDOW);
	localparam int DW = agtr_pkg::SAMPLE_W + 2 * AW + 1;

	agtr_pkg::coef_t              coef_q;
	logic [agtr_pkg::HOP_W-1:0]   hop_length_q;

	logic                                 f_valid;
	logic                                 f_ready;
	logic signed [agtr_pkg::SAMPLE_W-1:0] f_sample;
	logic [AW-1:0]                        f_addr;
	logic [AW-1:0]                        f_start;
	logic                                 f_trig;

	logic                                 q_valid;
	logic                                 q_ready;
	logic [DW-1:0]                        q_data;

	logic                                 r_valid;
	logic                                 r_ready;
	agtr_pkg::tone_res_t                  r_res;

	// Register writes; an index past the list is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q       <= '0;
			hop_length_q <= agtr_pkg::HOP_RESET;
		end else if (cfg.valid) begin
			case (agtr_pkg::reg_idx_t'(cfg.index))
				agtr_pkg::REG_MARK_COS:   coef_q.mark_cos  <= $signed(cfg.data);
				agtr_pkg::REG_MARK_SIN:   coef_q.mark_sin  <= $signed(cfg.data);
				agtr_pkg::REG_SPACE_COS:  coef_q.space_cos <= $signed(cfg.data);
				agtr_pkg::REG_SPACE_SIN:  coef_q.space_sin <= $signed(cfg.data);
				agtr_pkg::REG_HOP_LENGTH: hop_length_q <= cfg.data[agtr_pkg::HOP_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end tracks window fill, oldest position and hop count, and
	// tags each sample with its write address and whether it starts a walk.
	agtr_front #(
		.WINDOW (WINDOW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (samples.valid),
		.in_ready   (samples.ready),
		.in_sample  (samples.audio_sample),
		.hop_length (hop_length_q),
		.cmd_valid  (f_valid),
		.cmd_ready  (f_ready),
		.cmd_sample (f_sample),
		.cmd_addr   (f_addr),
		.cmd_start  (f_start),
		.cmd_trig   (f_trig)
	);

	agtr_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   ({f_sample, f_addr, f_start, f_trig}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	// The back end owns the window memory and runs both recurrences.
	agtr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd_sample (q_data[DW-1 -: agtr_pkg::SAMPLE_W]),
		.cmd_addr   (q_data[2*AW:AW+1]),
		.cmd_start  (q_data[AW:1]),
		.cmd_trig   (q_data[0]),
		.coef       (coef_q),
		.res_valid  (r_valid),
		.res_ready  (r_ready),
		.res        (r_res)
	);

	agtr_ratio u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (r_valid),
		.res_ready (r_ready),
		.res       (r_res),
		.out_valid (ratios.valid),
		.out_ready (ratios.ready),
		.out_ratio (ratios.mark_ratio)
	);
endmodule

@@ rtl/agtr_checker.sv @@
module agtr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [agtr_pkg::RATIO_W-1:0] out_data,
	input logic                         cfg_ready
);
	// A result offered but not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// A stalled result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result changed");

	// No result is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	// The register port never back-pressures.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("register port not ready");
endmodule

bind afsk_goertzel_tone_ratio_top agtr_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (ratios.valid),
	.out_ready (ratios.ready),
	.out_data  (ratios.mark_ratio),
	.cfg_ready (cfg.ready)
);
